### rtl/core/srp_pkg.sv
// ----------------------------------------------------------------------------
// srp_pkg: shared types and constants for the shelf rectangle packer
// widths of the item fields, the configuration register indexes and the
// sequencer states
// ----------------------------------------------------------------------------
package srp_pkg;

  localparam int unsigned GlyphW       = 12;
  localparam int unsigned DimW         = 15;
  localparam int unsigned PosW         = 14;
  localparam int unsigned PadW         = 8;
  localparam int unsigned IdxW         = 5;
  localparam int unsigned DimCap       = 16384;
  localparam int unsigned DefMaxEntries = 32;
  localparam int unsigned CfgIdxW      = 1;

  localparam logic [CfgIdxW-1:0] REG_MAX_DIM = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_PADDING = 1'b1;

  typedef enum logic [9:0] {
    ST_LOAD   = 10'b0000000001,
    ST_SCAN   = 10'b0000000010,
    ST_CHECK  = 10'b0000000100,
    ST_SQRT   = 10'b0000001000,
    ST_CLAMP  = 10'b0000010000,
    ST_PACK   = 10'b0000100000,
    ST_RETRY  = 10'b0001000000,
    ST_EMIT   = 10'b0010000000,
    ST_FAIL   = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } state_t;

endpackage

### rtl/core/shelf_rect_packer.sv
// ----------------------------------------------------------------------------
// shelf_rect_packer: next-fit shelf packer for a set of rectangles
// loads rectangles, sizes a trial width and packs them into shelves
// ----------------------------------------------------------------------------
// sequence: loading takes one item at a time; after the last item of a set
//   a scan of the set, a check, 16 square-root steps, a clamp and the packing
//   trials (at most 15 trials) run before results stream out, one per item
//   and held by any output stall, then a closing state
// throughput: one rectangle per cycle while loading; not ready while packing
// reset: synchronous active-low rst_n clears the set and restores registers
//   to max_dimension 4096, padding 1
module shelf_rect_packer #(
  parameter int unsigned MAX_ENTRIES = srp_pkg::DefMaxEntries
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [srp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [srp_pkg::DimW-1:0]      cfg_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [23:0]                   in_tdata,  // glyph_width, glyph_height
  input  logic                          in_tuser,  // is_blank
  input  logic                          in_tlast,  // last_glyph
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // entry_index, pos_x, pos_y, box_width, box_height, atlas_width, atlas_height,
  // zero fill
  output logic [95:0]                   out_tdata,
  output logic [1:0]                    out_tuser, // entry_blank, failed
  output logic                          out_tlast  // last_result
);
  import srp_pkg::*;

  localparam int unsigned EW = $clog2(MAX_ENTRIES);
  localparam int unsigned AW = (EW < 1) ? 1 : EW;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  // configuration
  logic [DimW-1:0] max_dim_r;
  logic [PadW-1:0] pad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dim_r <= DimW'(4096);
      pad_r     <= PadW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_DIM: max_dim_r <= cfg_data;
        REG_PADDING: pad_r     <= cfg_data[PadW-1:0];
        default: ;
      endcase
    end
  end

  // effective dimension, clamped to the cap
  logic [DimW-1:0] md;
  logic [DimW:0]   pad2;
  assign md   = (max_dim_r > DimW'(DimCap)) ? DimW'(DimCap) : max_dim_r;
  assign pad2 = (DimW+1)'({pad_r, 1'b0});

  // size memory: width, height, blank
  logic [2*GlyphW:0] size_mem [MAX_ENTRIES];
  logic [2*PosW-1:0] place_mem [MAX_ENTRIES];

  state_t state_r, state_nxt;
  logic [CW-1:0]   count_r;
  logic            over_r;
  logic [CW-1:0]   ptr_r;
  logic [AW-1:0]   rd_addr;
  logic [2*GlyphW:0] rd_size_r;
  logic [2*PosW-1:0] rd_place_r;
  logic            rd_ok_r;     // read data matches ptr_r
  logic [31:0]     area_r;
  logic [DimW-1:0] widest_r;
  logic            pixels_r;
  logic            err_r;
  logic [15:0]     root_r;
  logic [15:0]     bit_r;
  logic [DimW-1:0] trial_r;
  logic [DimW:0]   x_r, y_r, shelf_r, used_r;
  logic [DimW-1:0] aw_r, ah_r;
  logic            wr_place;
  logic [2*PosW-1:0] wr_place_data;

  // out register
  logic            ov_r;
  logic [95:0]     od_r;
  logic [1:0]      ou_r;
  logic            ol_r;

  assign in_tready  = (state_r == ST_LOAD);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

  assign rd_addr = AW'(ptr_r);

  // decode of the entry at the read port
  logic [GlyphW-1:0] ew, eh;
  logic              eblank;
  logic [DimW:0]     pw, ph;
  assign ew     = rd_size_r[GlyphW-1:0];
  assign eh     = rd_size_r[2*GlyphW-1:GlyphW];
  assign eblank = rd_size_r[2*GlyphW] || ew == '0 || eh == '0;
  assign pw     = (DimW+1)'(ew) + pad2;
  assign ph     = (DimW+1)'(eh) + pad2;

  // shared multiplier: box area in scan, square of max dimension in check, root square in sqrt and clamp
  logic [16:0] mul_a, mul_b;
  logic [33:0] mul_p;
  logic [15:0] cand;
  assign cand = root_r | bit_r;
  always_comb begin
    if (state_r == ST_SQRT) begin
      mul_a = {1'b0, cand};
      mul_b = {1'b0, cand};
    end else if (state_r == ST_CLAMP) begin
      mul_a = {1'b0, root_r};
      mul_b = {1'b0, root_r};
    end else if (state_r == ST_CHECK) begin
      mul_a = {2'b0, md};
      mul_b = {2'b0, md};
    end else begin
      mul_a = {1'b0, pw};
      mul_b = {1'b0, ph};
    end
  end
  assign mul_p = mul_a * mul_b;

  logic last_entry;
  assign last_entry = (ptr_r == count_r - CW'(1));

  // packing step comb
  logic          wrap;
  logic [DimW:0] px, py;
  logic [DimW+1:0] x_end;
  logic [DimW:0] shelf_new;
  always_comb begin
    wrap  = (x_r != '0) && (pw > (DimW+1)'(trial_r) - x_r);
    px    = wrap ? '0 : x_r;
    py    = wrap ? y_r + shelf_r : y_r;
    x_end = (DimW+2)'(px) + (DimW+2)'(pw);
    shelf_new = wrap ? ph : ((ph > shelf_r) ? ph : shelf_r);
  end
  assign wr_place_data = {py[PosW-1:0], px[PosW-1:0]};

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready && count_r < CW'(MAX_ENTRIES))
      size_mem[AW'(count_r)] <= {in_tuser, in_tdata[2*GlyphW-1:0]};
    if (wr_place)
      place_mem[rd_addr] <= wr_place_data;
    rd_size_r  <= size_mem[rd_addr];
    rd_place_r <= place_mem[rd_addr];
  end

  logic ow_done;
  assign ow_done = !ov_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    wr_place  = 1'b0;
    case (state_r)
      ST_LOAD:  if (in_tvalid && in_tlast) state_nxt = ST_SCAN;
      ST_SCAN:  if (rd_ok_r && (last_entry || err_r)) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = ST_SQRT;
      ST_SQRT: begin
        // an error or a set with no pixels skips the search
        if (err_r) state_nxt = ST_FAIL;
        else if (!pixels_r) state_nxt = ST_EMIT;
        else if (bit_r == 16'd1) state_nxt = ST_CLAMP;
      end
      ST_CLAMP: state_nxt = ST_PACK;
      ST_PACK: begin
        if (rd_ok_r) begin
          if (!eblank) begin
            if (pw > (DimW+1)'(trial_r) ||
                ph > (DimW+1)'(md) - py || py > (DimW+1)'(md))
              state_nxt = ST_RETRY;
            else begin
              wr_place = 1'b1;
              if (last_entry) state_nxt = ST_EMIT;
            end
          end else if (last_entry) state_nxt = ST_EMIT;
        end
      end
      ST_RETRY: state_nxt = (trial_r == md) ? ST_FAIL : ST_PACK;
      ST_EMIT:  if (rd_ok_r && ow_done && last_entry) state_nxt = ST_DONE;
      ST_FAIL:  if (ow_done) state_nxt = ST_DONE;
      ST_DONE:  if (ow_done) state_nxt = ST_LOAD;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  logic [DimW-1:0] aw_fin, ah_fin;
  logic [DimW+1:0] used_fin;
  logic [DimW+1:0] h_fin;
  assign used_fin = (ST_PACK == state_r && !eblank && x_end > (DimW+2)'(used_r)) ?
                    x_end : (DimW+2)'(used_r);
  assign h_fin    = (!eblank) ? (DimW+2)'(py) + (DimW+2)'(shelf_new)
                              : (DimW+2)'(y_r) + (DimW+2)'(shelf_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      over_r  <= 1'b0;
      ptr_r   <= '0;
      rd_ok_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ow_done) ov_r <= 1'b0;
      case (state_r)
        ST_LOAD: begin
          rd_ok_r <= 1'b0;
          ptr_r   <= '0;
          area_r  <= '0;
          widest_r <= DimW'(1);
          pixels_r <= 1'b0;
          err_r    <= (md == '0) || ((DimW+1)'(pad_r) > (DimW+1)'(md >> 1));
          if (in_tvalid) begin
            if (count_r < CW'(MAX_ENTRIES)) count_r <= count_r + CW'(1);
            else over_r <= 1'b1;
            if (count_r >= CW'(MAX_ENTRIES)) err_r <= 1'b1;
          end
          if (in_tvalid && in_tlast && count_r >= CW'(MAX_ENTRIES)) err_r <= 1'b1;
          if (over_r) err_r <= 1'b1;
        end
        ST_SCAN: begin
          rd_ok_r <= 1'b1;
          if (rd_ok_r) begin
            rd_ok_r <= 1'b0;
            ptr_r   <= ptr_r + CW'(1);
            if (!eblank) begin
              pixels_r <= 1'b1;
              if ((DimW+1)'(ew) + pad2 > (DimW+1)'(md) ||
                  (DimW+1)'(eh) + pad2 > (DimW+1)'(md))
                err_r <= 1'b1;
              if (pw > (DimW+1)'(widest_r)) widest_r <= pw[DimW-1:0];
              area_r <= area_r + mul_p[31:0];
            end
          end
          if (state_nxt != ST_SCAN) begin
            ptr_r <= '0;
            rd_ok_r <= 1'b0;
          end
        end
        ST_CHECK: begin
          if ({2'b0, area_r} > mul_p) err_r <= 1'b1;
          root_r <= '0;
          bit_r  <= 16'h8000;
        end
        ST_SQRT: begin
          if (mul_p <= {2'b0, area_r}) root_r <= cand;
          bit_r <= bit_r >> 1;
          aw_r <= DimW'(1);
          ah_r <= DimW'(1);
        end
        ST_CLAMP: begin
          begin : clamp_blk
            logic [16:0] r;
            r = {1'b0, root_r} + ((mul_p[31:0] < area_r) ? 17'd1 : 17'd0);
            if (r < 17'(widest_r)) r = 17'(widest_r);
            if (r > 17'(md)) r = 17'(md);
            trial_r <= r[DimW-1:0];
          end
          x_r <= '0; y_r <= '0; shelf_r <= '0; used_r <= '0;
          ptr_r <= '0; rd_ok_r <= 1'b0;
        end
        ST_PACK: begin
          rd_ok_r <= 1'b1;
          if (rd_ok_r) begin
            rd_ok_r <= 1'b0;
            ptr_r <= ptr_r + CW'(1);
            if (!eblank) begin
              x_r     <= x_end[DimW:0];
              y_r     <= py;
              shelf_r <= shelf_new;
              used_r  <= used_fin[DimW:0];
            end
            if (state_nxt == ST_EMIT) begin
              aw_r  <= (used_fin > (DimW+2)'(1)) ? used_fin[DimW-1:0] : DimW'(1);
              ah_r  <= (h_fin > (DimW+2)'(1)) ? h_fin[DimW-1:0] : DimW'(1);
              ptr_r <= '0;
            end
          end
        end
        ST_RETRY: begin
          trial_r <= ((DimW+1)'(trial_r) > (DimW+1)'(md >> 1)) ? md : trial_r << 1;
          x_r <= '0; y_r <= '0; shelf_r <= '0; used_r <= '0;
          ptr_r <= '0; rd_ok_r <= 1'b0;
        end
        ST_EMIT: begin
          rd_ok_r <= 1'b1;
          if (rd_ok_r && ow_done) begin
            rd_ok_r <= 1'b0;
            ptr_r   <= ptr_r + CW'(1);
            ov_r    <= 1'b1;
            od_r    <= {3'b0, ah_r, aw_r,
                        eblank ? DimW'(0) : ph[DimW-1:0],
                        eblank ? DimW'(0) : pw[DimW-1:0],
                        eblank ? PosW'(0) : rd_place_r[2*PosW-1:PosW],
                        eblank ? PosW'(0) : rd_place_r[PosW-1:0],
                        IdxW'(ptr_r)};
            ou_r    <= {1'b0, eblank};
            ol_r    <= last_entry;
          end
        end
        ST_FAIL: begin
          if (ow_done) begin
            ov_r <= 1'b1;
            od_r <= '0;
            ou_r <= 2'b10;
            ol_r <= 1'b1;
          end
        end
        ST_DONE: begin
          count_r <= '0;
          over_r  <= 1'b0;
          ptr_r   <= '0;
          rd_ok_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD) |-> !in_tready) else $error("ready while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES)) else $error("entry count overflow");
  a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> out_tlast) else $error("fail not last");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");
`endif

endmodule
